// ===== hdl/lcdss_pkg.sv =====
// Package for the LCD serial frame sender: command codes, state codes,
// field widths and frame ID patterns. No dependencies.
package lcdss_pkg;

   localparam int CMD_W   = 3;
   localparam int VALUE_W = 8;
   localparam int ADDR_W  = 7;
   localparam int WORD_W  = 10;
   localparam int COUNT_W = 4;

   // Input command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_OPEN_CMD   = 3'd0,
      CMD_CMD_BYTE   = 3'd1,
      CMD_OPEN_WRITE = 3'd2,
      CMD_DATA_BYTE  = 3'd3,
      CMD_CLOSE      = 3'd4
   } cmd_type;

   // Sequencer states, one-hot
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   // Frame ID patterns, sent first
   localparam logic [2:0] ID_COMMAND = 3'b100;
   localparam logic [2:0] ID_WRITE   = 3'b101;

   // Bit counts per command
   localparam logic [COUNT_W-1:0] N_ID       = 4'd3;
   localparam logic [COUNT_W-1:0] N_CMD_BYTE = 4'd9;
   localparam logic [COUNT_W-1:0] N_WRITE    = 4'd10;
   localparam logic [COUNT_W-1:0] N_DATA     = 4'd8;
   localparam logic [COUNT_W-1:0] N_CLOSE    = 4'd1;

endpackage

// ===== hdl/lcd_driver_serial_frame_sender.sv =====
// The first result of an item enters the output register once the sequencer
// is in its send state. An item gives n results, n being its result count
// (3 open command, 9 command byte, 10 open write, 8 data byte, 1 close);
// unused codes give none. A new item is taken only when idle. The single
// shift register emits one bit per cycle unless the output stalls.
// Synchronous active-high reset clears sequencer and output valid, not chip select.
// Top level: shift-register sequencer of the three-wire serial frame sender.
// Depends on lcdss_pkg.
module lcd_driver_serial_frame_sender
   import lcdss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [ADDR_W-1:0]  req_address,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_chip_select_n,
   output logic               rsp_strobe_res,
   output logic               rsp_data_bit,
   output logic               rsp_last
);

   state_type           state_ff, state_in;
   logic                selected_ff, selected_in;
   logic                close_ff, close_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                cs_n_ff, cs_n_in;
   logic                strobe_ff, strobe_in;
   logic                data_ff, data_in;
   logic                last_ff, last_in;
   logic                take;
   logic                emit;

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;
   assign emit      = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_ready);

   // Sequencer: load the shift word on transfer, shift one bit per emit
   always_comb begin
      state_in    = state_ff;
      selected_in = selected_ff;
      close_in    = close_ff;
      word_in     = word_ff;
      count_in    = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (req_command)
                  CMD_OPEN_CMD: begin
                     selected_in = 1'b1;
                     close_in    = 1'b0;
                     word_in     = {ID_COMMAND, 7'd0};
                     count_in    = N_ID;
                     state_in    = ST_SEND;
                  end
                  CMD_CMD_BYTE: begin
                     close_in = 1'b0;
                     word_in  = {req_value, 2'b00};
                     count_in = N_CMD_BYTE;
                     state_in = ST_SEND;
                  end
                  CMD_OPEN_WRITE: begin
                     selected_in = 1'b1;
                     close_in    = 1'b0;
                     word_in     = {ID_WRITE, req_address};
                     count_in    = N_WRITE;
                     state_in    = ST_SEND;
                  end
                  CMD_DATA_BYTE: begin
                     close_in = 1'b0;
                     word_in  = {req_value, 2'b00};
                     count_in = N_DATA;
                     state_in = ST_SEND;
                  end
                  CMD_CLOSE: begin
                     selected_in = 1'b0;
                     close_in    = 1'b1;
                     word_in     = {1'b1, 9'd0};
                     count_in    = N_CLOSE;
                     state_in    = ST_SEND;
                  end
                  default: begin
                     // unused codes: no result, no state change
                  end
               endcase
            end
         end
         ST_SEND: begin
            if (emit) begin
               word_in  = {word_ff[WORD_W-2:0], 1'b0};
               count_in = count_ff - 1'b1;
               if (count_ff == 4'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: filled on emit, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      cs_n_in      = cs_n_ff;
      strobe_in    = strobe_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         cs_n_in      = close_ff | ~selected_ff;
         strobe_in    = ~close_ff;
         data_in      = word_ff[WORD_W-1];
         last_in      = (count_ff == 4'd1);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         selected_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         selected_ff  <= selected_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      close_ff  <= close_in;
      word_ff   <= word_in;
      cs_n_ff   <= cs_n_in;
      strobe_ff <= strobe_in;
      data_ff   <= data_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chip_select_n = cs_n_ff;
   assign rsp_strobe_res    = strobe_ff;
   assign rsp_data_bit      = data_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== hdl/lcdss_checker.sv =====
// Port-level checker for the LCD serial frame sender, bound to the top level.
// Depends on lcdss_pkg.
module lcdss_checker
   import lcdss_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [CMD_W-1:0]   req_command,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_chip_select_n,
   input logic               rsp_strobe_res,
   input logic               rsp_data_bit,
   input logic               rsp_last
);

   // No result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chip_select_n)
         && $stable(rsp_strobe_res) && $stable(rsp_data_bit) && $stable(rsp_last))
      else $error("stalled result changed");

   // A non-strobe result is a close: deselected, data high, last
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_strobe_res |-> rsp_chip_select_n && rsp_data_bit && rsp_last)
      else $error("malformed close result");

   // A valid command keeps the input busy the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_OPEN_CMD
         || req_command == CMD_CMD_BYTE || req_command == CMD_OPEN_WRITE
         || req_command == CMD_DATA_BYTE || req_command == CMD_CLOSE)
      |=> !req_ready)
      else $error("ready while sending");

endmodule

bind lcd_driver_serial_frame_sender lcdss_checker u_lcdss_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_command       (req_command),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_chip_select_n (rsp_chip_select_n),
   .rsp_strobe_res    (rsp_strobe_res),
   .rsp_data_bit      (rsp_data_bit),
   .rsp_last          (rsp_last)
);
